// ===== design/tpc_pkg.sv =====
// Shared types and codes for the trie prefix counter.
package tpc_pkg;

  localparam int LETTER_WIDTH = 5;
  localparam int PREFIX_WIDTH = 16;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [LETTER_WIDTH-1:0] letter;
    logic                    last_letter;
    logic                    no_letter;
  } in_item_t;

  typedef struct packed {
    logic                    request_kind;
    logic [PREFIX_WIDTH-1:0] prefix_count;
    logic                    pool_overflow;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic clear;
    logic kill;
    logic kill_ovf;
    logic rd_node;
    logic follow;
    logic alloc;
    logic init_node;
    logic cnt_rd;
    logic cnt_wr;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dead;
    logic letter_ok;
    logic present;
    logic full;
    logic is_insert;
    logic last;
    logic out_free;
  } stat_t;

endpackage

// ===== design/tpc_datapath.sv =====
// Datapath: node pool memories, walk registers and the result register.
module tpc_datapath #(
  parameter int NODE_COUNT  = 4096,
  parameter int ALPHABET    = 26,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  tpc_pkg::in_item_t   in_item,
  input  tpc_pkg::cmd_t       cmd,
  output tpc_pkg::stat_t      stat,
  input  logic                out_stall,
  output logic                out_valid,
  output tpc_pkg::out_item_t  out_item
);

  localparam int NW         = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
  localparam int LW         = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
  localparam int LINK_DEPTH = NODE_COUNT * ALPHABET;
  localparam int AW         = $clog2(LINK_DEPTH);

  localparam logic [NW-1:0]          LAST_NODE = NW'(NODE_COUNT - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [ALPHABET-1:0]    present_mem [NODE_COUNT];
  logic [NW-1:0]          link_mem    [LINK_DEPTH];
  logic [COUNT_WIDTH-1:0] count_mem   [NODE_COUNT];

  logic [ALPHABET-1:0]    present_q;
  logic [NW-1:0]          link_q;
  logic [COUNT_WIDTH-1:0] count_q;

  logic [1:0]             req;
  logic                   last;
  logic [LW-1:0]          letter_q;
  logic [AW-1:0]          link_addr;
  logic [NW-1:0]          cur;
  logic [NW-1:0]          next_free;
  logic                   dead;
  logic                   overflow_seen;
  logic [ALPHABET-1:0]    root_present;

  logic [LW-1:0]          letter_in;
  logic [ALPHABET-1:0]    present_row;
  logic [ALPHABET-1:0]    letter_bit;
  logic [NW-1:0]          fresh;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [31:0]            count_wide;
  logic [tpc_pkg::PREFIX_WIDTH-1:0] count_out;
  logic                   pres_we;
  logic [ALPHABET-1:0]    pres_wdata;
  logic                   cnt_we;
  logic [COUNT_WIDTH-1:0] cnt_wdata;

  assign letter_in   = LW'(32'(in_item.letter));
  assign present_row = (cur == '0) ? root_present : present_q;
  assign fresh       = next_free + NW'(1);
  assign count_inc   = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_WIDTH'(1);
  assign count_wide  = 32'(count_q);

  always_comb begin
    letter_bit = '0;
    letter_bit[letter_q] = 1'b1;
  end

  always_comb begin
    if (dead || cur == '0) begin
      count_out = '0;
    end else if (count_wide > 32'(COUNT_MAX) || count_wide > 32'hFFFF) begin
      count_out = (count_wide > 32'hFFFF) ? '1 : tpc_pkg::PREFIX_WIDTH'(count_wide);
    end else begin
      count_out = tpc_pkg::PREFIX_WIDTH'(count_wide);
    end
  end

  assign stat.dead      = dead;
  assign stat.letter_ok = (32'(in_item.letter) < 32'(ALPHABET));
  assign stat.present   = present_row[letter_q];
  assign stat.full      = (next_free == LAST_NODE);
  assign stat.is_insert = (req == tpc_pkg::REQ_INSERT);
  assign stat.last      = last;
  assign stat.out_free  = !out_valid || !out_stall;

  // present row writes: mark a new child on a non-root node, or blank a fresh node
  assign pres_we    = (cmd.alloc && cur != '0) || cmd.init_node;
  assign pres_wdata = cmd.init_node ? '0 : (present_row | letter_bit);
  assign cnt_we     = cmd.cnt_wr || cmd.init_node;
  assign cnt_wdata  = cmd.init_node ? COUNT_WIDTH'(1) : count_inc;

  always_ff @(posedge clk) begin
    if (pres_we) begin
      present_mem[cur] <= pres_wdata;
    end
    if (cmd.rd_node) begin
      present_q <= present_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      link_mem[link_addr] <= fresh;
    end
    if (cmd.rd_node) begin
      link_q <= link_mem[link_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cur] <= cnt_wdata;
    end
    if (cmd.cnt_rd) begin
      count_q <= count_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req       <= in_item.req_type;
      last      <= in_item.last_letter;
      letter_q  <= letter_in;
      link_addr <= AW'(32'(cur) * 32'(ALPHABET) + 32'(letter_in));
    end
    if (cmd.finish) begin
      out_item.request_kind  <= req[0];
      out_item.prefix_count  <= count_out;
      out_item.pool_overflow <= (req == tpc_pkg::REQ_INSERT) && overflow_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur           <= '0;
      next_free     <= '0;
      dead          <= 1'b0;
      overflow_seen <= 1'b0;
      root_present  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear) begin
        cur           <= '0;
        next_free     <= '0;
        dead          <= 1'b0;
        overflow_seen <= 1'b0;
        root_present  <= '0;
      end
      if (cmd.kill) begin
        dead <= 1'b1;
      end
      if (cmd.kill_ovf) begin
        dead          <= 1'b1;
        overflow_seen <= 1'b1;
      end
      if (cmd.follow) begin
        cur <= link_q;
      end
      if (cmd.alloc) begin
        cur       <= fresh;
        next_free <= fresh;
        if (cur == '0) begin
          root_present <= root_present | letter_bit;
        end
      end
      if (cmd.finish) begin
        out_valid     <= 1'b1;
        cur           <= '0;
        dead          <= 1'b0;
        overflow_seen <= 1'b0;
      end
    end
  end

endmodule

// ===== design/tpc_ctrl.sv =====
// Controller: sequences each letter through the node pool memories.
module tpc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tpc_pkg::in_item_t  in_item,
  input  tpc_pkg::stat_t     stat,
  output tpc_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_ALLOC  = 3'd3;
  localparam logic [2:0] S_CREAD  = 3'd4;
  localparam logic [2:0] S_CWRITE = 3'd5;
  localparam logic [2:0] S_FREAD  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] done_state;
  logic       accept;
  logic       walk;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && (state == S_IDLE);
  assign walk       = !in_item.no_letter && !stat.dead;
  assign done_state = stat.last ? S_FREAD : S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          if (in_item.req_type >= tpc_pkg::REQ_CLEAR) begin
            cmd.clear = 1'b1;
          end else if (walk && stat.letter_ok) begin
            state_next = S_READ;
          end else begin
            cmd.kill   = walk;
            state_next = in_item.last_letter ? S_FREAD : S_IDLE;
          end
        end
      end
      S_READ: begin
        cmd.rd_node = 1'b1;
        state_next  = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.present) begin
          cmd.follow = 1'b1;
          state_next = stat.is_insert ? S_CREAD : done_state;
        end else if (!stat.is_insert) begin
          cmd.kill   = 1'b1;
          state_next = done_state;
        end else if (stat.full) begin
          cmd.kill_ovf = 1'b1;
          state_next   = done_state;
        end else begin
          cmd.alloc  = 1'b1;
          state_next = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd.init_node = 1'b1;
        state_next    = done_state;
      end
      S_CREAD: begin
        cmd.cnt_rd = 1'b1;
        state_next = S_CWRITE;
      end
      S_CWRITE: begin
        cmd.cnt_wr = 1'b1;
        state_next = done_state;
      end
      S_FREAD: begin
        cmd.cnt_rd = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/trie_prefix_counter_unit.sv =====
// Trie prefix counter: top level joining the controller and the datapath.
// Usage:
//   Input channel (in_valid/in_stall/in_item) takes one letter of a string per
//   item; last_letter closes the string, no_letter marks an item without a
//   letter, req_type selects insert, query or clear of the whole trie.
//   Output channel (out_valid/out_stall/out_item) gives one item per finished
//   insert or query string: its kind, the prefix count of the final node
//   (0 if the walk fell off the trie) and the pool overflow flag.
// Timing:
//   in_stall is low only while the controller waits for an item. A letter is
//   latched, then its node is read and the child tested: a query follows the
//   link, an insert through an existing node reads then writes its count, and
//   an insert that allocates a node initializes it. Items with no letter, or
//   on a dead walk, skip the node read. The last item then reads the final
//   count and loads the result register. Each letter's walk waits on the
//   dependent synchronous read of its child link. Clear gives no result.
// Reset clears the root, allocator and walk; no memory sweep is needed since
// nodes are initialized when allocated. While out_stall holds a result, new
// items are still taken until a further string finishes and must wait.
module trie_prefix_counter_unit #(
  parameter int NODE_COUNT  = 4096,
  parameter int ALPHABET    = 26,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpc_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tpc_pkg::out_item_t  out_item
);

  tpc_pkg::cmd_t  cmd;
  tpc_pkg::stat_t stat;

  tpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .stat     (stat),
    .cmd      (cmd)
  );

  tpc_datapath #(
    .NODE_COUNT  (NODE_COUNT),
    .ALPHABET    (ALPHABET),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_rise_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result appeared without a finish");

  a_alloc_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> (stat.is_insert && !stat.full && !stat.present))
    else $error("node allocated when not allowed");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish || cmd.rd_node || cmd.alloc) |-> in_stall)
    else $error("item taken while a walk step runs");

  a_ovf_only_insert: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.pool_overflow) |->
      (out_item.request_kind == tpc_pkg::KIND_INSERT && out_item.prefix_count == '0))
    else $error("overflow flag on a query or with a live count");

endmodule

// ===== tb/sv/trie_prefix_counter_unit_tb.sv =====
// Self-checking testbench for the trie prefix counter unit.
module trie_prefix_counter_unit_tb;
  import tpc_pkg::*;

  localparam int unsigned NODE_LIMIT  = 4096;
  localparam int unsigned LETTERS     = 26;
  localparam int          COUNT_WIDTH = 16;
  localparam int unsigned COUNT_MAX   = (1 << COUNT_WIDTH) - 1;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int          BANK_SIZE   = 48;
  // spare request code, decodes as clear
  localparam logic [1:0]  REQ_SPARE   = 2'd3;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  trie_prefix_counter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // trie mirror
  int unsigned link_tab [NODE_LIMIT*LETTERS];
  bit [25:0]   kid_mask [NODE_LIMIT];
  int unsigned node_hits [NODE_LIMIT];
  int unsigned walk_node;
  int unsigned alloc_top;
  bit          walk_off;
  bit          walk_ovf;

  out_item_t   pending_counts[$];
  logic [39:0] bank_word[$];
  int          bank_len[$];

  int          idle_pct;
  int          stall_pct;
  int          stall_hold;
  int          n_letters;
  int          n_results;
  int          n_errors;
  int unsigned n_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void trie_clear();
    kid_mask[0]  = '0;
    node_hits[0] = 0;
    walk_node    = 0;
    alloc_top    = 0;
    walk_off     = 1'b0;
    walk_ovf     = 1'b0;
  endfunction

  function automatic void trie_walk_letter(bit ins, int unsigned l);
    int unsigned slot;
    if (walk_off) return;
    if (l >= LETTERS) begin
      walk_off = 1'b1;
      return;
    end
    slot = walk_node * LETTERS + l;
    if (!kid_mask[walk_node][l]) begin
      if (!ins) begin
        walk_off = 1'b1;
        return;
      end
      if (alloc_top + 1 >= NODE_LIMIT) begin
        walk_off = 1'b1;
        walk_ovf = 1'b1;
        return;
      end
      alloc_top++;
      kid_mask[alloc_top]    = '0;
      node_hits[alloc_top]   = 0;
      link_tab[slot]         = alloc_top;
      kid_mask[walk_node][l] = 1'b1;
    end
    walk_node = link_tab[slot];
    if (ins && node_hits[walk_node] < COUNT_MAX) node_hits[walk_node]++;
  endfunction

  function automatic void trie_accept_item(in_item_t it);
    out_item_t r;
    if (it.req_type >= REQ_CLEAR) begin
      trie_clear();
      return;
    end
    if (!it.no_letter) trie_walk_letter(it.req_type == REQ_INSERT, 32'(it.letter));
    if (!it.last_letter) return;
    r.request_kind  = (it.req_type == REQ_INSERT) ? KIND_INSERT : KIND_QUERY;
    r.prefix_count  = walk_off ? '0 : PREFIX_WIDTH'(node_hits[walk_node]);
    r.pool_overflow = (it.req_type == REQ_INSERT) && walk_ovf;
    pending_counts.push_back(r);
    walk_node = 0;
    walk_off  = 1'b0;
    walk_ovf  = 1'b0;
  endfunction

  function automatic in_item_t letter_item(logic [1:0] req, logic [LETTER_WIDTH-1:0] l,
                                           logic last, logic nol);
    in_item_t it;
    it.req_type    = req;
    it.letter      = l;
    it.last_letter = last;
    it.no_letter   = nol;
    return it;
  endfunction

  function automatic logic [39:0] rand_word(int len, int hi);
    logic [39:0] w;
    w = '0;
    for (int i = 0; i < len; i++) w[i*5 +: 5] = 5'($urandom_range(0, hi));
    return w;
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!(it.no_letter && !it.last_letter)) n_letters++;
    trie_accept_item(it);
  endtask

  task automatic send_word(logic [1:0] req, logic [39:0] w, int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 3)
        send_item(letter_item(req, 5'($urandom_range(0, 31)), 1'b0, 1'b1));
      send_item(letter_item(req, w[i*5 +: 5], i == len - 1, 1'b0));
    end
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_counts.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(letter_item(REQ_QUERY, 5'd0, 1'b1, 1'b0));
    send_item(letter_item(REQ_INSERT, 5'd0, 1'b1, 1'b0));
    send_item(letter_item(REQ_INSERT, 5'd0, 1'b0, 1'b0));
    send_item(letter_item(REQ_INSERT, 5'd1, 1'b1, 1'b0));
    send_item(letter_item(REQ_QUERY, 5'd0, 1'b1, 1'b0));
    send_item(letter_item(REQ_INSERT, 5'd25, 1'b1, 1'b0));
    send_item(letter_item(REQ_INSERT, 5'd31, 1'b1, 1'b0));
    send_item(letter_item(REQ_QUERY, 5'd26, 1'b1, 1'b0));
    send_item(letter_item(REQ_INSERT, 5'd31, 1'b1, 1'b1));
    send_item(letter_item(REQ_QUERY, 5'd0, 1'b1, 1'b1));
    // string closed by an item without a letter
    send_item(letter_item(REQ_INSERT, 5'd0, 1'b0, 1'b0));
    send_item(letter_item(REQ_INSERT, 5'd21, 1'b1, 1'b1));
    // query then insert on one walk
    send_item(letter_item(REQ_QUERY, 5'd0, 1'b0, 1'b0));
    send_item(letter_item(REQ_INSERT, 5'd1, 1'b1, 1'b0));
    // dead walk ignores the rest
    send_item(letter_item(REQ_INSERT, 5'd30, 1'b0, 1'b0));
    send_item(letter_item(REQ_INSERT, 5'd0, 1'b1, 1'b0));
    // clear in the middle of a string
    send_item(letter_item(REQ_INSERT, 5'd0, 1'b0, 1'b0));
    send_item(letter_item(REQ_CLEAR, 5'd0, 1'b0, 1'b0));
    send_item(letter_item(REQ_QUERY, 5'd0, 1'b1, 1'b0));
    send_item(letter_item(REQ_INSERT, 5'd10, 1'b1, 1'b0));
    send_item(letter_item(REQ_SPARE, 5'd16, 1'b1, 1'b0));
    send_item(letter_item(REQ_QUERY, 5'd10, 1'b1, 1'b0));
  endtask

  task automatic send_noise_string();
    int len;
    int roll;
    logic [1:0] req;
    logic [LETTER_WIDTH-1:0] l;
    len = $urandom_range(1, 5);
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      req  = (roll < 45) ? REQ_INSERT : (roll < 90) ? REQ_QUERY :
             (roll < 95) ? REQ_CLEAR : REQ_SPARE;
      roll = $urandom_range(0, 99);
      l    = (roll < 80) ? 5'($urandom_range(0, 5)) :
             (roll < 90) ? 5'($urandom_range(0, 25)) : 5'($urandom_range(26, 31));
      send_item(letter_item(req, l, i == len - 1, $urandom_range(0, 99) < 10));
    end
  endtask

  task automatic test_random_traffic(int n);
    int stop;
    int roll;
    int len;
    int k;
    logic [39:0] w;
    stop = n_letters + n;
    while (n_letters < stop) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        if (bank_word.size() != 0 && $urandom_range(0, 99) < 30) begin
          k = $urandom_range(0, bank_word.size() - 1);
          send_word(REQ_INSERT, bank_word[k], bank_len[k]);
        end else begin
          len = $urandom_range(1, 6);
          w   = rand_word(len, ($urandom_range(0, 99) < 70) ? 3 : 25);
          send_word(REQ_INSERT, w, len);
          if (bank_word.size() < BANK_SIZE) begin
            bank_word.push_back(w);
            bank_len.push_back(len);
          end else begin
            k = $urandom_range(0, BANK_SIZE - 1);
            bank_word[k] = w;
            bank_len[k]  = len;
          end
        end
      end else if (roll < 75) begin
        if (bank_word.size() != 0 && $urandom_range(0, 99) < 70) begin
          k = $urandom_range(0, bank_word.size() - 1);
          send_word(REQ_QUERY, bank_word[k], $urandom_range(1, bank_len[k]));
        end else begin
          len = $urandom_range(1, 6);
          send_word(REQ_QUERY, rand_word(len, 3), len);
        end
      end else if (roll < 77) begin
        send_item(letter_item(($urandom_range(0, 1) != 0) ? REQ_CLEAR : REQ_SPARE,
                              5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 1'b0));
      end else begin
        send_noise_string();
      end
    end
  endtask

  task automatic test_backpressure();
    idle_pct   = 0;
    stall_pct  = 0;
    stall_hold = 400;
    repeat (20) send_word(REQ_INSERT, rand_word(3, 3), 3);
  endtask

  task automatic test_pause();
    repeat (10) send_word(REQ_QUERY, rand_word(2, 3), 2);
    wait_results_done();
    repeat (10) send_word(REQ_INSERT, rand_word(2, 3), 2);
  endtask

  task automatic test_repeated_prefix();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(letter_item(REQ_CLEAR, 5'd0, 1'b0, 1'b0));
    repeat (40) send_item(letter_item(REQ_INSERT, 5'd7, 1'b1, 1'b0));
    send_item(letter_item(REQ_INSERT, 5'd7, 1'b0, 1'b0));
    send_item(letter_item(REQ_INSERT, 5'd2, 1'b1, 1'b0));
    send_item(letter_item(REQ_QUERY, 5'd7, 1'b1, 1'b0));
    send_item(letter_item(REQ_CLEAR, 5'd0, 1'b0, 1'b0));
    send_item(letter_item(REQ_QUERY, 5'd7, 1'b1, 1'b0));
    // nodes must come back fresh after a clear
    send_item(letter_item(REQ_INSERT, 5'd7, 1'b0, 1'b0));
    send_item(letter_item(REQ_INSERT, 5'd2, 1'b1, 1'b0));
    send_item(letter_item(REQ_QUERY, 5'd7, 1'b1, 1'b0));
  endtask

  // result checker and cycle limit
  initial begin
    out_item_t want;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (pending_counts.size() == 0) begin
          $error("result with nothing pending: %p", out_item);
          n_errors++;
        end else begin
          want = pending_counts.pop_front();
          if (out_item.request_kind !== want.request_kind) begin
            $error("request_kind: expected %0d, got %0d",
                   want.request_kind, out_item.request_kind);
            n_errors++;
          end
          if (out_item.prefix_count !== want.prefix_count) begin
            $error("prefix_count: expected %0d, got %0d",
                   want.prefix_count, out_item.prefix_count);
            n_errors++;
          end
          if (out_item.pool_overflow !== want.pool_overflow) begin
            $error("pool_overflow: expected %0d, got %0d",
                   want.pool_overflow, out_item.pool_overflow);
            n_errors++;
          end
        end
      end
      if (stall_hold > 0) begin
        out_stall <= 1'b1;
        stall_hold--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    in_item    <= '0;
    idle_pct   = 0;
    stall_pct  = 0;
    stall_hold = 0;
    n_letters  = 0;
    n_results  = 0;
    n_errors   = 0;
    n_cycles   = 0;
    trie_clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    idle_pct = 0;  stall_pct = 0;  test_random_traffic(450);
    idle_pct = 87; stall_pct = 0;  test_random_traffic(350);
    idle_pct = 0;  stall_pct = 87; test_random_traffic(350);
    idle_pct = 6;  stall_pct = 6;  test_random_traffic(350);
    test_backpressure();
    test_pause();
    test_repeated_prefix();

    wait_results_done();
    repeat (20) @(posedge clk);
    $display("Sent %0d letter items and checked %0d results over mixed random strings,",
             n_letters, n_results);
    $display("a long output hold, a repeated prefix and idle and stall mixes on both sides.");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
